### design/itda_pkg.sv
// Package for the integer to decimal ASCII converter.
// Holds the format opcodes, character constants and the control struct.
// No dependencies.
`timescale 1ns / 1ps

package itda_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int OP_W            = 2;
   localparam int CHAR_W          = 6;

   // format opcodes
   localparam logic [OP_W-1:0] OP_VAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_FIX2 = 2'd1;
   localparam logic [OP_W-1:0] OP_FIX4 = 2'd2;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

   // commands to the double-dabble shifter
   typedef struct packed {
      logic load;    // take a new magnitude, clear BCD
      logic dabble;  // add-3 correction then shift one binary bit in
      logic dshift;  // shift BCD left by one digit
   } dab_ctrl_type;

endpackage

### design/integer_to_decimal_ascii_top.sv
// Top level of the integer to decimal ASCII converter.
// Depends on itda_pkg and itda_dabble.
`timescale 1ns / 1ps

// Converts a signed integer to decimal ASCII text, one character per
// transaction on the result channel.
//  req channel: tdata = {value, opcode}; opcode in bits [1:0], value above.
//    opcode 0: variable width, leading '-' for negatives, no leading zeros.
//    opcode 1/2: exactly two/four digits of the value mod 100/10000,
//    negatives print as zeros. opcode 3 is accepted and dropped.
//  rsp channel: tdata[5:0] = ASCII code, tlast on the final character.
// One transaction is taken only when the block is idle, so a new number
// waits until the last character of the previous one is in the output
// register. After the accept the double-dabble shifter takes in one binary
// bit per cycle, then the sequencer walks the NUM_DIGITS BCD digit slots,
// each either skipped as a leading digit or emitted, and sends a '-' sign
// ahead of the digits of a negative number. The dabble loop over the input
// bits sets most of the conversion time.
// Characters leave through a one-entry output register; a stalled receiver
// simply holds the emit sequence, nothing is lost.
// Reset (synchronous, active high) returns the sequencer to idle and
// empties the output register.
module integer_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF,
   localparam int REQ_W      = ((VALUE_WIDTH + itda_pkg::OP_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // [1:0] opcode, [VALUE_WIDTH+1:2] value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [5:0] char_code
   output logic             rsp_tlast    // last character of the number
);

   // enough digits for 2^(VALUE_WIDTH-1), and never fewer than four
   localparam int DIG_RAW    = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int NUM_DIGITS = (DIG_RAW < 4) ? 4 : DIG_RAW;
   localparam int BW         = $clog2(VALUE_WIDTH);
   localparam int DW         = $clog2(NUM_DIGITS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CONV = 4'b0010,
      S_SKIP = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [BW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DW-1:0] left_ff, left_in;      // digit slots not yet consumed
   logic [DW-1:0] keep_ff, keep_in;      // digits that must be printed
   logic          fixed_ff, fixed_in;
   logic          minus_ff, minus_in;    // '-' still to be sent

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [itda_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [itda_pkg::OP_W-1:0] req_op;
   logic [VALUE_WIDTH-1:0]    req_value;
   logic [VALUE_WIDTH-1:0]    mag;
   logic                      req_neg;
   logic                      accept;
   logic                      slot_free;
   logic [3:0]                top_digit;
   itda_pkg::dab_ctrl_type    ctrl;

   assign req_op    = req_tdata[itda_pkg::OP_W-1:0];
   assign req_value = req_tdata[itda_pkg::OP_W +: VALUE_WIDTH];
   assign req_neg   = req_value[VALUE_WIDTH-1];
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // magnitude: fixed formats clamp negatives to zero; the negate of the
   // most negative value is read as unsigned 2^(VALUE_WIDTH-1)
   always_comb begin
      if (!req_neg) mag = req_value;
      else if (req_op == itda_pkg::OP_VAR) mag = ~req_value + 1'b1;
      else mag = '0;
   end

   itda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_dabble (
      .clock     (clock),
      .ctrl      (ctrl),
      .mag       (mag),
      .top_digit (top_digit)
   );

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      left_in      = left_ff;
      keep_in      = keep_ff;
      fixed_in     = fixed_ff;
      minus_in     = minus_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      req_tready   = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_op inside {itda_pkg::OP_VAR, itda_pkg::OP_FIX2,
                                          itda_pkg::OP_FIX4})) begin
               ctrl.load  = 1'b1;
               bit_cnt_in = BW'(VALUE_WIDTH - 1);
               left_in    = DW'(NUM_DIGITS);
               fixed_in   = (req_op != itda_pkg::OP_VAR);
               minus_in   = (req_op == itda_pkg::OP_VAR) && req_neg;
               case (req_op)
                  itda_pkg::OP_FIX2: keep_in = DW'(2);
                  itda_pkg::OP_FIX4: keep_in = DW'(4);
                  default:           keep_in = DW'(1);
               endcase
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            ctrl.dabble = 1'b1;
            bit_cnt_in  = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) state_in = S_SKIP;
         end
         S_SKIP: begin
            // drop leading zero digits, or the high digits of a fixed format
            if (left_ff > keep_ff && (fixed_ff || top_digit == 4'd0)) begin
               ctrl.dshift = 1'b1;
               left_in     = left_ff - 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (minus_ff) begin
                  rsp_char_in = itda_pkg::CH_MINUS;
                  rsp_last_in = 1'b0;
                  minus_in    = 1'b0;
               end else begin
                  rsp_char_in = itda_pkg::CH_ZERO + {2'b00, top_digit};
                  rsp_last_in = (left_ff == DW'(1));
                  ctrl.dshift = 1'b1;
                  left_in     = left_ff - 1'b1;
                  if (left_ff == DW'(1)) state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_cnt_ff  <= bit_cnt_in;
      left_ff     <= left_in;
      keep_ff     <= keep_in;
      fixed_ff    <= fixed_in;
      minus_ff    <= minus_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a sign character never ends a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_char_ff == itda_pkg::CH_MINUS |-> !rsp_tlast)
      else $error("minus sign marked last");

   // every character is a digit or a minus sign
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_char_ff >= itda_pkg::CH_ZERO &&
                      rsp_char_ff <= itda_pkg::CH_ZERO + 6'd9) ||
                     rsp_char_ff == itda_pkg::CH_MINUS)
      else $error("bad character code");

   // digit slots remain while skipping or emitting
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SKIP || state_ff == S_EMIT) |-> left_ff != '0)
      else $error("digit count underflow");

   // a stalled character is not overwritten
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_char_ff) &&
                                    $stable(rsp_last_ff))
      else $error("output overwritten under stall");

endmodule

### design/itda_dabble.sv
// Bit-serial double-dabble shifter: binary magnitude in, BCD digits out.
// Depends on itda_pkg (control struct).
`timescale 1ns / 1ps

module itda_dabble #(
   parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF,
   parameter int NUM_DIGITS  = 10
) (
   input  logic                   clock,
   input  itda_pkg::dab_ctrl_type ctrl,
   input  logic [VALUE_WIDTH-1:0] mag,
   output logic [3:0]             top_digit
);

   localparam int BCD_W = NUM_DIGITS * 4;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       adj;

   // add 3 to every digit of 5 or more, digits are independent
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = mag;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
      end else if (ctrl.dshift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule
